@@ rtl/core/tsw_pkg.sv @@
`default_nettype none
package tsw_pkg;

  localparam int MAX_WIDTH_DEF        = 256;
  localparam int MAX_HEIGHT_DEF       = 256;
  localparam int COORD_FRAC_BITS_DEF  = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 8;

  localparam int SIZE_W     = 9;
  localparam int TEXEL_W    = 32;
  localparam int COORD_W    = 24;
  localparam int ADDR_IN_W  = 16;
  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_WRAP_MODE_S  = 3'd2,
    REG_WRAP_MODE_T  = 3'd3,
    REG_FILTER_MODE  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    WRAP_CLAMP  = 2'd0,
    WRAP_REPEAT = 2'd1,
    WRAP_MIRROR = 2'd2
  } wrap_t;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

endpackage
`default_nettype wire

@@ rtl/core/tsw_ram.sv @@
`default_nettype none
module tsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/texture_sampler_wrap_bilinear.sv @@
`default_nettype none
// Texture sampler: an RGBA8 image sits row-major in two mirrored texel RAMs with two read
// ports each, so the four bilinear taps are read in the same cycle. Every write item
// is copied into both RAMs; a write at or beyond MAX_WIDTH*MAX_HEIGHT is dropped. The
// pipeline takes one item per cycle, but it all holds while a result waits on out_stall.
// A sample result passes the wrap, scale, index, RAM, weighting and output registers.
// Writes and reads hit the RAMs in the same stage, so program order is kept without
// forwarding. Nearest filtering runs through the blend path with zero weights. A zero
// image size returns opaque black. Reads of texels never written return unspecified data.
module texture_sampler_wrap_bilinear #(
  parameter int MAX_WIDTH        = tsw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT       = tsw_pkg::MAX_HEIGHT_DEF,
  parameter int COORD_FRAC_BITS  = tsw_pkg::COORD_FRAC_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = tsw_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_kind,
  input  wire logic [tsw_pkg::ADDR_IN_W-1:0]      in_texel_address,
  input  wire logic [tsw_pkg::TEXEL_W-1:0]        in_texel_value,
  input  wire logic signed [tsw_pkg::COORD_W-1:0] in_coord_s,
  input  wire logic signed [tsw_pkg::COORD_W-1:0] in_coord_t,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [tsw_pkg::CHAN_W-1:0]              out_red,
  output logic [tsw_pkg::CHAN_W-1:0]              out_green,
  output logic [tsw_pkg::CHAN_W-1:0]              out_blue,
  output logic [tsw_pkg::CHAN_W-1:0]              out_alpha,
  input  wire logic                               cfg_we,
  input  wire logic [tsw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [tsw_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CF    = COORD_FRAC_BITS;
  localparam int W     = WEIGHT_FRAC_BITS;
  localparam int SZW   = tsw_pkg::SIZE_W;
  localparam int STW   = CF + 1;
  localparam int PW    = STW + SZW;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = ($clog2(MAX_WIDTH) < SZW) ? $clog2(MAX_WIDTH) : SZW;
  localparam int YW    = ($clog2(MAX_HEIGHT) < SZW) ? $clog2(MAX_HEIGHT) : SZW;
  localparam int SHR   = (CF >= W) ? CF - W : 0;
  localparam int SHL   = (W > CF) ? W - CF : 0;
  localparam int WW    = 2 * W + 2;
  localparam int PRW   = WW + tsw_pkg::CHAN_W;
  localparam int SUMW  = PRW + 2;
  localparam int TW    = tsw_pkg::TEXEL_W;
  localparam int CW    = tsw_pkg::CHAN_W;

  typedef struct packed {
    logic [SZW-1:0] i0;
    logic [SZW-1:0] i1;
    logic [W-1:0]   wt;
  } axis_t;

  // configuration
  logic [SZW-1:0] width_r, height_r;
  logic [1:0]     wrap_s_r, wrap_t_r;
  logic           filter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      wrap_s_r <= tsw_pkg::WRAP_CLAMP;
      wrap_t_r <= tsw_pkg::WRAP_CLAMP;
      filter_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsw_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        tsw_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
        tsw_pkg::REG_WRAP_MODE_S:  wrap_s_r <= cfg_data[1:0];
        tsw_pkg::REG_WRAP_MODE_T:  wrap_t_r <= cfg_data[1:0];
        tsw_pkg::REG_FILTER_MODE:  filter_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [SZW-1:0] w_eff, h_eff;
  logic           no_image;

  assign w_eff    = (32'(width_r) > MAX_WIDTH) ? SZW'(MAX_WIDTH) : width_r;
  assign h_eff    = (32'(height_r) > MAX_HEIGHT) ? SZW'(MAX_HEIGHT) : height_r;
  assign no_image = (w_eff == '0) || (h_eff == '0);

  function automatic logic [STW-1:0] wrap_coord(input logic signed [tsw_pkg::COORD_W-1:0] c,
                                                input logic [1:0] m);
    logic signed [25:0] ce;
    logic [CF-1:0]      fr;
    logic [STW-1:0]     r;
    ce = 26'(c);
    fr = ce[CF-1:0];
    case (m)
      tsw_pkg::WRAP_CLAMP: begin
        if (ce < 0) r = '0;
        else if (ce > $signed(26'(1) <<< CF)) r = STW'(1) << CF;
        else r = ce[CF:0];
      end
      tsw_pkg::WRAP_REPEAT: r = {1'b0, fr};
      tsw_pkg::WRAP_MIRROR: r = ce[CF] ? (STW'(1) << CF) - STW'(fr) : STW'(fr);
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic axis_t axis_index(input logic [PW-1:0] p, input logic [SZW-1:0] n,
                                       input logic [1:0] m, input logic f);
    logic [PW-1:0]          q;
    logic signed [PW+1:0]   pu, i0, i1, ns;
    logic [CF+W-1:0]        ft;
    axis_t                  r;
    ns = $signed((PW+2)'(n));
    if (!f) begin
      q = p >> CF;
      if (q >= PW'(n)) q = PW'(n) - PW'(1);
      r.i0 = SZW'(q);
      r.i1 = SZW'(q);
      r.wt = '0;
    end else begin
      pu = $signed({2'b00, p}) - $signed((PW+2)'(1) <<< (CF - 1));
      i0 = pu >>> CF;
      if (m == tsw_pkg::WRAP_REPEAT && i0 < 0) i0 = ns - 1;
      i1 = i0 + 1;
      if (m == tsw_pkg::WRAP_REPEAT && i1 == ns) i1 = '0;
      if (i0 < 0) i0 = '0;
      if (i1 > ns - 1) i1 = ns - 1;
      ft   = (CF+W)'(pu[CF-1:0]);
      ft   = (ft >> SHR) << SHL;
      r.i0 = SZW'(i0);
      r.i1 = SZW'(i1);
      r.wt = ft[W-1:0];
    end
    return r;
  endfunction

  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // stage 1: wrap
  logic                          v1_r, k1_r;
  logic [tsw_pkg::ADDR_IN_W-1:0] wa1_r;
  logic [TW-1:0]                 wd1_r;
  logic [STW-1:0]                s1_r, t1_r;
  // stage 2: coordinate times size
  logic                          v2_r, k2_r;
  logic [tsw_pkg::ADDR_IN_W-1:0] wa2_r;
  logic [TW-1:0]                 wd2_r;
  logic [PW-1:0]                 ps2_r, pt2_r;
  // stage 3: indices and weights
  logic                          v3_r, k3_r;
  logic [tsw_pkg::ADDR_IN_W-1:0] wa3_r;
  logic [TW-1:0]                 wd3_r;
  logic [XW-1:0]                 x0_r, x1_r;
  logic [YW-1:0]                 y0_r, y1_r;
  logic [W-1:0]                  a3_r, b3_r;
  // stage 4: RAM access and corner weights
  logic                          v4_r;
  logic [WW-1:0]                 wt4_r [4];
  // stage 5: weighted channels
  logic                          v5_r;
  logic [PRW-1:0]                prod_r [4][4];
  logic [CW-1:0]                 chan_r [4];

  axis_t ax_s, ax_t;

  assign ax_s = axis_index(ps2_r, w_eff, wrap_s_r, filter_r);
  assign ax_t = axis_index(pt2_r, h_eff, wrap_t_r, filter_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r && (k3_r == tsw_pkg::KIND_SAMPLE);
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_r  <= in_kind;
      wa1_r <= in_texel_address;
      wd1_r <= in_texel_value;
      s1_r  <= wrap_coord(in_coord_s, wrap_s_r);
      t1_r  <= wrap_coord(in_coord_t, wrap_t_r);

      k2_r  <= k1_r;
      wa2_r <= wa1_r;
      wd2_r <= wd1_r;
      ps2_r <= PW'(s1_r) * PW'(w_eff);
      pt2_r <= PW'(t1_r) * PW'(h_eff);

      k3_r  <= k2_r;
      wa3_r <= wa2_r;
      wd3_r <= wd2_r;
      x0_r  <= XW'(ax_s.i0);
      x1_r  <= XW'(ax_s.i1);
      y0_r  <= YW'(ax_t.i0);
      y1_r  <= YW'(ax_t.i1);
      a3_r  <= ax_s.wt;
      b3_r  <= ax_t.wt;
    end
  end

  // corner weights
  logic [W:0] wa_c, wb_c;

  assign wa_c = (W+1)'(1) << W;
  assign wb_c = (W+1)'(1) << W;

  always_ff @(posedge clk) begin
    if (adv) begin
      wt4_r[0] <= WW'(wa_c - (W+1)'(a3_r)) * WW'(wb_c - (W+1)'(b3_r));
      wt4_r[1] <= WW'(a3_r) * WW'(wb_c - (W+1)'(b3_r));
      wt4_r[2] <= WW'(wa_c - (W+1)'(a3_r)) * WW'(b3_r);
      wt4_r[3] <= WW'(a3_r) * WW'(b3_r);
    end
  end

  // row addresses
  logic [AW-1:0] row0, row1, ad00, ad10, ad01, ad11;
  logic          ram_we;

  assign row0   = AW'(y0_r) * AW'(w_eff);
  assign row1   = AW'(y1_r) * AW'(w_eff);
  assign ad00   = row0 + AW'(x0_r);
  assign ad10   = row0 + AW'(x1_r);
  assign ad01   = row1 + AW'(x0_r);
  assign ad11   = row1 + AW'(x1_r);
  assign ram_we = adv && v3_r && (k3_r == tsw_pkg::KIND_WRITE) && (32'(wa3_r) < DEPTH);

  logic [TW-1:0] tx [4];

  tsw_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_ram_row0 (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (AW'(wa3_r)),
    .wdata   (wd3_r),
    .re      (adv),
    .raddr_a (ad00),
    .raddr_b (ad10),
    .rdata_a (tx[0]),
    .rdata_b (tx[1])
  );

  tsw_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_ram_row1 (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (AW'(wa3_r)),
    .wdata   (wd3_r),
    .re      (adv),
    .raddr_a (ad01),
    .raddr_b (ad11),
    .rdata_a (tx[2]),
    .rdata_b (tx[3])
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        for (int c = 0; c < 4; c++) begin
          prod_r[i][c] <= PRW'(wt4_r[i]) * PRW'(tx[i][8*c +: 8]);
        end
      end
    end
  end

  // sum the four taps, round and saturate
  logic [SUMW-1:0] sum_c [4];
  logic [SUMW-1:0] rnd_c [4];
  logic [CW-1:0]   blend_c [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_c[c] = SUMW'(prod_r[0][c]) + SUMW'(prod_r[1][c])
               + SUMW'(prod_r[2][c]) + SUMW'(prod_r[3][c]);
      rnd_c[c] = (sum_c[c] + (SUMW'(1) << (2*W - 1))) >> (2*W);
      blend_c[c] = (rnd_c[c] > SUMW'(255)) ? CW'(255) : CW'(rnd_c[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        if (no_image) chan_r[c] <= (c == 3) ? CW'(255) : CW'(0);
        else chan_r[c] <= blend_c[c];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_blue  = chan_r[0];
  assign out_green = chan_r[1];
  assign out_red   = chan_r[2];
  assign out_alpha = chan_r[3];

endmodule
`default_nettype wire

@@ tb/texture_sampler_wrap_bilinear_test.sv @@
module texture_sampler_wrap_bilinear_test;

  localparam longint ONE = 64'sd1 << tsw_pkg::COORD_FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES = 12;

  typedef logic signed [tsw_pkg::COORD_W-1:0] coord_t;
  typedef logic [tsw_pkg::ADDR_IN_W-1:0] addr_t;
  typedef logic [tsw_pkg::CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [tsw_pkg::CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t UNUSED_REG_IDX = 3'd6;

  typedef struct {
    logic                        kind;
    addr_t                       addr;
    logic [tsw_pkg::TEXEL_W-1:0] value;
    coord_t                      cs;
    coord_t                      ct;
  } tex_item_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  addr_t in_texel_address = '0;
  logic [tsw_pkg::TEXEL_W-1:0] in_texel_value = '0;
  coord_t in_coord_s = '0;
  coord_t in_coord_t = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [tsw_pkg::CHAN_W-1:0] out_red, out_green, out_blue, out_alpha;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = '0;
  cfg_data_t cfg_data = '0;

  tex_item_t pending_items[$];
  pixel_t expected_pixels[$];
  logic [31:0] texmem [65536];
  int img_w = 0, img_h = 0, wrap_s = 0, wrap_t = 0, filt = 0;
  int fails = 0;
  int cyc = 0;
  int results_seen = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;

  texture_sampler_wrap_bilinear u_top (.*);

  always #4 clk = ~clk;

  always @(posedge clk) cyc <= cyc + 1;

  function automatic bit quiet_window();
    return (cyc % 1000) >= 800;
  endfunction

  function automatic longint wrap_coord(longint c, int m);
    longint f;
    f = c & (ONE - 1);
    case (m)
      tsw_pkg::WRAP_CLAMP:  return c < 0 ? 0 : (c > ONE ? ONE : c);
      tsw_pkg::WRAP_REPEAT: return f;
      tsw_pkg::WRAP_MIRROR: return ((c >>> tsw_pkg::COORD_FRAC_BITS_DEF) & 1) ? ONE - f : f;
      default:              return 0;
    endcase
  endfunction

  function automatic longint clampi(longint i, longint n);
    return i < 0 ? 0 : (i > n - 1 ? n - 1 : i);
  endfunction

  function automatic longint posmod(longint i, longint n);
    longint r;
    r = i % n;
    return r < 0 ? r + n : r;
  endfunction

  function automatic logic [31:0] texel_at(longint x, longint y, longint w, longint h);
    return texmem[w * clampi(y, h) + clampi(x, w)];
  endfunction

  // Filter one sample against the current image and settings.
  function automatic pixel_t filter_sample(coord_t cs, coord_t ct);
    longint w, h, s, t, pu, pv, i0, j0, i1, j1, a, b, sum;
    logic [31:0] t00, t10, t01, t11, px;
    pixel_t res;
    w = img_w > tsw_pkg::MAX_WIDTH_DEF ? tsw_pkg::MAX_WIDTH_DEF : img_w;
    h = img_h > tsw_pkg::MAX_HEIGHT_DEF ? tsw_pkg::MAX_HEIGHT_DEF : img_h;
    if (w == 0 || h == 0) return '{8'd0, 8'd0, 8'd0, 8'd255};
    s = wrap_coord(longint'(cs), wrap_s);
    t = wrap_coord(longint'(ct), wrap_t);
    if (filt == 0) begin
      px = texel_at((s * w) >>> tsw_pkg::COORD_FRAC_BITS_DEF,
                    (t * h) >>> tsw_pkg::COORD_FRAC_BITS_DEF, w, h);
    end else begin
      pu = s * w - ONE / 2;
      pv = t * h - ONE / 2;
      i0 = pu >>> tsw_pkg::COORD_FRAC_BITS_DEF;
      j0 = pv >>> tsw_pkg::COORD_FRAC_BITS_DEF;
      a = (pu & (ONE - 1)) >> (tsw_pkg::COORD_FRAC_BITS_DEF - tsw_pkg::WEIGHT_FRAC_BITS_DEF);
      b = (pv & (ONE - 1)) >> (tsw_pkg::COORD_FRAC_BITS_DEF - tsw_pkg::WEIGHT_FRAC_BITS_DEF);
      if (wrap_s == tsw_pkg::WRAP_REPEAT) i0 = posmod(i0, w);
      if (wrap_t == tsw_pkg::WRAP_REPEAT) j0 = posmod(j0, h);
      i1 = i0 + 1;
      j1 = j0 + 1;
      if (wrap_s == tsw_pkg::WRAP_REPEAT) i1 = posmod(i1, w);
      if (wrap_t == tsw_pkg::WRAP_REPEAT) j1 = posmod(j1, h);
      t00 = texel_at(i0, j0, w, h);
      t10 = texel_at(i1, j0, w, h);
      t01 = texel_at(i0, j1, w, h);
      t11 = texel_at(i1, j1, w, h);
      for (int ch = 0; ch < 4; ch++) begin
        sum = (256 - a) * (256 - b) * ((t00 >> (8 * ch)) & 255)
            + a * (256 - b) * ((t10 >> (8 * ch)) & 255)
            + (256 - a) * b * ((t01 >> (8 * ch)) & 255)
            + a * b * ((t11 >> (8 * ch)) & 255);
        sum = (sum + 32768) >> 16;
        if (sum > 255) sum = 255;
        px[8*ch +: 8] = sum[7:0];
      end
    end
    res.r = px[23:16];
    res.g = px[15:8];
    res.b = px[7:0];
    res.a = px[31:24];
    return res;
  endfunction

  // Sender: hold while stalled, advance on transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      tex_item_t it;
      int head;
      head = 0;
      if (in_valid) begin
        it = pending_items[0];
        if (it.kind == tsw_pkg::KIND_WRITE) texmem[it.addr] = it.value;
        else expected_pixels.push_back(filter_sample(it.cs, it.ct));
        head = 1;
      end
      if (pending_items.size() > head && (quiet_window() || $urandom_range(99) >= 22)) begin
        it = pending_items[head];
        in_valid <= 1'b1;
        in_kind <= it.kind;
        in_texel_address <= it.addr;
        in_texel_value <= it.value;
        in_coord_s <= it.cs;
        in_coord_t <= it.ct;
      end else begin
        in_valid <= 1'b0;
      end
      if (head != 0) void'(pending_items.pop_front());
    end
  end

  // Receiver: check each transfer, stall at random, and once hold off for a long stretch.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      pixel_t exp_px;
      if (expected_pixels.size() == 0) begin
        $error("unexpected result r=%0d g=%0d b=%0d a=%0d",
               out_red, out_green, out_blue, out_alpha);
        fails++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_red !== exp_px.r) begin
          $error("red expected %0d actual %0d", exp_px.r, out_red); fails++;
        end
        if (out_green !== exp_px.g) begin
          $error("green expected %0d actual %0d", exp_px.g, out_green); fails++;
        end
        if (out_blue !== exp_px.b) begin
          $error("blue expected %0d actual %0d", exp_px.b, out_blue); fails++;
        end
        if (out_alpha !== exp_px.a) begin
          $error("alpha expected %0d actual %0d", exp_px.a, out_alpha); fails++;
        end
      end
      results_seen++;
    end
    if (!hold_done && results_seen >= 40) begin
      hold_done <= 1'b1;
      hold_cnt <= 150;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet_window() && $urandom_range(99) < 22;
    end
  end

  task automatic set_reg(cfg_idx_t idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= cfg_data_t'(val);
    case (idx)
      tsw_pkg::REG_IMAGE_WIDTH:  img_w = val;
      tsw_pkg::REG_IMAGE_HEIGHT: img_h = val;
      tsw_pkg::REG_WRAP_MODE_S:  wrap_s = val;
      tsw_pkg::REG_WRAP_MODE_T:  wrap_t = val;
      tsw_pkg::REG_FILTER_MODE:  filt = val;
      default: ;
    endcase
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'(longint'($urandom_range(5 * 65536)) - 2 * ONE);
      2: return coord_t'($urandom_range(65536));
      default: return coord_t'(longint'($urandom_range(16)) * (ONE / 16) - ONE / 32);
    endcase
  endfunction

  task automatic push_sample(coord_t cs, coord_t ct);
    pending_items.push_back('{tsw_pkg::KIND_SAMPLE, addr_t'($urandom), $urandom, cs, ct});
  endtask

  task automatic run_phase(int w, int h, int ws, int wt, int f, int nrand);
    int ew, eh;
    wait (pending_items.size() == 0 && !in_valid && expected_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    set_reg(tsw_pkg::REG_IMAGE_WIDTH, w);
    set_reg(tsw_pkg::REG_IMAGE_HEIGHT, h);
    set_reg(tsw_pkg::REG_WRAP_MODE_S, ws);
    set_reg(tsw_pkg::REG_WRAP_MODE_T, wt);
    set_reg(tsw_pkg::REG_FILTER_MODE, f);
    @(posedge clk);
    cfg_we <= 1'b0;
    ew = w > tsw_pkg::MAX_WIDTH_DEF ? tsw_pkg::MAX_WIDTH_DEF : w;
    eh = h > tsw_pkg::MAX_HEIGHT_DEF ? tsw_pkg::MAX_HEIGHT_DEF : h;
    // fill the whole image so no sample touches an unwritten texel
    for (int i = 0; i < ew * eh; i++)
      pending_items.push_back('{tsw_pkg::KIND_WRITE, addr_t'(i), $urandom,
                                rand_coord(), rand_coord()});
    push_sample('0, '0);
    push_sample(coord_t'(ONE), coord_t'(ONE));
    push_sample(coord_t'(-1), coord_t'(ONE - 1));
    push_sample(24'sh800000, 24'sh7fffff);
    push_sample(24'sh7fffff, 24'sh800000);
    push_sample(coord_t'(ONE / 2), coord_t'(3 * ONE / 2));
    for (int i = 0; i < nrand; i++) begin
      if ($urandom_range(99) < 25) begin
        addr_t ad;
        ad = ($urandom_range(1) && ew * eh > 0) ? addr_t'($urandom_range(ew * eh - 1))
                                                : addr_t'($urandom);
        pending_items.push_back('{tsw_pkg::KIND_WRITE, ad, $urandom,
                                  rand_coord(), rand_coord()});
      end else begin
        push_sample(rand_coord(), rand_coord());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    set_reg(UNUSED_REG_IDX, 9'h1ff);
    run_phase(0, 5, tsw_pkg::WRAP_CLAMP, tsw_pkg::WRAP_CLAMP, 0, 4);
    run_phase(4, 4, tsw_pkg::WRAP_CLAMP, tsw_pkg::WRAP_CLAMP, 0, 20);
    run_phase(4, 4, tsw_pkg::WRAP_REPEAT, tsw_pkg::WRAP_REPEAT, 1, 30);
    run_phase(3, 5, tsw_pkg::WRAP_MIRROR, tsw_pkg::WRAP_MIRROR, 1, 30);
    run_phase(6, 2, 3, tsw_pkg::WRAP_REPEAT, 1, 14);
    run_phase(2, 6, tsw_pkg::WRAP_CLAMP, tsw_pkg::WRAP_MIRROR, 0, 14);
    run_phase(511, 1, tsw_pkg::WRAP_REPEAT, 3, 1, 10);
    run_phase(1, 1, tsw_pkg::WRAP_REPEAT, tsw_pkg::WRAP_CLAMP, 1, 6);
    run_phase(7, 3, tsw_pkg::WRAP_MIRROR, tsw_pkg::WRAP_REPEAT, 0, 14);
    run_phase(5, 0, tsw_pkg::WRAP_MIRROR, tsw_pkg::WRAP_MIRROR, 1, 4);
    wait (pending_items.size() == 0 && !in_valid && expected_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/tsw_pkg.sv
rtl/core/tsw_ram.sv
rtl/core/texture_sampler_wrap_bilinear.sv
tb/texture_sampler_wrap_bilinear_test.sv
